// File: design/tog_pkg.sv
// Shared widths, codes and the 5x7 font table of the text overlay rasterizer.
package tog_pkg;

    localparam int MAX_CHARS_DEF = 16;
    localparam int MAX_SCALE_DEF = 8;

    localparam int FUNC_W      = 1;
    localparam int CHAR_SLOT_W = 4;
    localparam int CHAR_CODE_W = 4;
    localparam int PIXEL_X_W   = 10;
    localparam int PIXEL_Y_W   = 7;
    localparam int COLOR_W     = 8;
    localparam int SCALE_W     = 4;
    localparam int TEXT_LEN_W  = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE       = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_LENGTH = 1'b1;

    localparam logic [COLOR_W-1:0] INK_LEVEL = 8'd255;
    localparam logic [COLOR_W-1:0] INK_ALPHA = 8'd235;
    localparam logic [COLOR_W-1:0] BOX_ALPHA = 8'd150;

    localparam int GLYPH_COUNT = 12;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;

    // One entry per glyph row; bit 4 is the leftmost column.
    localparam logic [4:0] FONT_ROWS [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10},
        '{5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13}
    };

    function automatic logic font_pixel(input logic [CHAR_CODE_W-1:0] code,
                                        input logic [2:0] row,
                                        input logic [2:0] col);
        logic [4:0] bits;
        logic       hit;
        bits = 5'd0;
        hit  = 1'b0;
        if (code < GLYPH_COUNT && row < GLYPH_ROWS && col < GLYPH_COLS)
        begin
            bits = FONT_ROWS[code][row];
            hit  = bits[3'(GLYPH_COLS - 1) - col];
        end
        return hit;
    endfunction

endpackage

// File: design/tog_in_if.sv
// Input channel carrying write and pixel-query transactions.
interface tog_in_if;
    logic                               valid;
    logic                               ready;
    logic [tog_pkg::FUNC_W-1:0]         func;
    logic [tog_pkg::CHAR_SLOT_W-1:0]    char_slot;
    logic [tog_pkg::CHAR_CODE_W-1:0]    char_code;
    logic [tog_pkg::PIXEL_X_W-1:0]      pixel_x;
    logic [tog_pkg::PIXEL_Y_W-1:0]      pixel_y;

    modport source (output valid, func, char_slot, char_code, pixel_x, pixel_y,
                    input ready);
    modport sink (input valid, func, char_slot, char_code, pixel_x, pixel_y,
                  output ready);
endinterface

// File: design/tog_out_if.sv
// Output channel carrying one RGBA pixel per query transaction.
interface tog_out_if;
    logic                           valid;
    logic                           ready;
    logic [tog_pkg::COLOR_W-1:0]    red;
    logic [tog_pkg::COLOR_W-1:0]    green;
    logic [tog_pkg::COLOR_W-1:0]    blue;
    logic [tog_pkg::COLOR_W-1:0]    alpha;
    logic                           in_image;

    modport source (output valid, red, green, blue, alpha, in_image, input ready);
    modport sink (input valid, red, green, blue, alpha, in_image, output ready);
endinterface

// File: design/tog_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tog_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: design/text_overlay_glyph_rasterizer.sv
// Text overlay rasterizer: 5x7 character generator answering per-pixel RGBA queries.
//
// The item channel takes two kinds of transaction. A write (func 0) stores char_code
// at char_slot in the text store and gives no result. A query (func 1) returns one
// pixel on the result channel: white with alpha 235 on a glyph, black with alpha 150
// on the box, all zero with in_image low outside the image or when the text is empty.
// A query holds the item channel while it passes through the restoring divider that
// finds the character cell, whose quotient width NW is the width of the character
// index, $clog2(MAX_CHARS + 1), then a state that reads the text store, then a state
// that looks up the font and forms the pixel; that state waits while the output
// register is full and then loads the result into it. The user must write the scale
// and text_length registers through the cfg port only while no query is in flight;
// the block does not enforce this. Reset sets scale to 1 and text_length to 0 and
// empties the output register; the text store is not cleared and must be written
// before it is shown. When the receiver stalls, the finished result waits in the
// output register and the block still accepts the next transaction; a second
// finished query then waits until the first is taken.
module text_overlay_glyph_rasterizer #(
    parameter int MAX_CHARS = tog_pkg::MAX_CHARS_DEF,
    parameter int MAX_SCALE = tog_pkg::MAX_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tog_in_if.sink                             item,
    tog_out_if.source                          result,
    input  logic                               cfg_wen,
    input  logic [tog_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tog_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int NW     = $clog2(MAX_CHARS + 1);
    localparam int STEP_W = $clog2(NW + 1);
    localparam int CELL_W = 7;
    localparam int PAD_W  = 5;
    localparam int H_W    = 8;
    localparam int W_W    = (CELL_W + NW + 1 > tog_pkg::PIXEL_X_W) ?
                            CELL_W + NW + 1 : tog_pkg::PIXEL_X_W + 1;
    localparam int CMP_W  = tog_pkg::PIXEL_X_W + CELL_W + NW;
    localparam int XW     = tog_pkg::PIXEL_X_W;
    localparam int YW     = tog_pkg::PIXEL_Y_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic [XW-1:0]                      rem_reg, rem_next;
    logic [NW-1:0]                      q_reg, q_next;
    logic [YW-1:0]                      roff_reg, roff_next;
    logic                               inside_reg, inside_next;
    logic                               area_reg, area_next;
    logic [2:0]                         row_reg, row_next;
    logic [2:0]                         col_reg, col_next;
    logic                               ci_ok_reg, ci_ok_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tog_pkg::COLOR_W-1:0]        level_reg, level_next;
    logic [tog_pkg::COLOR_W-1:0]        alpha_reg, alpha_next;
    logic                               in_image_reg, in_image_next;
    logic [tog_pkg::SCALE_W-1:0]        scale_reg;
    logic [tog_pkg::TEXT_LEN_W-1:0]     text_length_reg;

    logic [tog_pkg::SCALE_W-1:0]        s;
    logic [NW-1:0]                      n;
    logic [PAD_W-1:0]                   pad;
    logic [CELL_W-1:0]                  cell_span;
    logic [W_W-1:0]                     img_w;
    logic [H_W-1:0]                     img_h;
    logic [CMP_W-1:0]                   div_sub;
    logic                               div_ge;
    logic [6:0]                         row_hits;
    logic [4:0]                         col_hits;
    logic                               accept;
    logic                               out_free;
    logic                               ink;

    logic                               ram_we;
    logic [AW+tog_pkg::CHAR_SLOT_W-1:0] slot_wide;
    logic [tog_pkg::CHAR_CODE_W-1:0]    ram_rdata;

    tog_ram #(
        .WIDTH (tog_pkg::CHAR_CODE_W),
        .DEPTH (MAX_CHARS)
    ) u_text_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_wide[AW-1:0]),
        .wdata (item.char_code),
        .re    (state_reg == ST_READ),
        .raddr (q_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s = (int'(scale_reg) > MAX_SCALE) ? tog_pkg::SCALE_W'(MAX_SCALE) : scale_reg;
    assign n = (int'(text_length_reg) > MAX_CHARS) ? NW'(MAX_CHARS) : NW'(text_length_reg);
    assign pad       = {s, 1'b0};
    assign cell_span = CELL_W'({s, 2'b00}) + CELL_W'({s, 1'b0});
    assign img_w     = W_W'(cell_span) * W_W'(n) + W_W'({s, 1'b0}) + W_W'(s);
    assign img_h     = H_W'(s) * H_W'(11);

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign slot_wide  = {{AW{1'b0}}, item.char_slot};
    assign ram_we     = accept && item.func == tog_pkg::FUNC_WRITE &&
                        int'(item.char_slot) < MAX_CHARS;

    function automatic logic [STEP_W-1:0] step_next_shift(input logic [STEP_W-1:0] step);
        return step - STEP_W'(1);
    endfunction

    assign div_sub = CMP_W'(cell_span) << step_next_shift(step_reg);
    assign div_ge  = CMP_W'(rem_reg) >= div_sub;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        for (int k = 1; k <= 7; k++)
        begin
            row_hits[k-1] = {1'b0, roff_reg} >= (8'(s) * 8'(k));
        end
        for (int k = 1; k <= 5; k++)
        begin
            col_hits[k-1] = rem_reg >= (XW'(s) * XW'(k));
        end
    end

    assign ink = inside_reg && area_reg && ci_ok_reg &&
                 tog_pkg::font_pixel(ram_rdata, row_reg, col_reg);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        roff_next      = roff_reg;
        inside_next    = inside_reg;
        area_next      = area_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ci_ok_next     = ci_ok_reg;
        level_next     = level_reg;
        alpha_next     = alpha_reg;
        in_image_next  = in_image_reg;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.func == tog_pkg::FUNC_QUERY)
                begin
                    inside_next = s != '0 && n != '0 &&
                                  W_W'(item.pixel_x) < img_w &&
                                  H_W'(item.pixel_y) < img_h;
                    area_next   = item.pixel_x >= XW'(pad) && item.pixel_y >= YW'(pad);
                    rem_next    = item.pixel_x - XW'(pad);
                    roff_next   = item.pixel_y - YW'(pad);
                    q_next      = '0;
                    step_next   = STEP_W'(NW);
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - XW'(div_sub);
                end
                q_next    = (q_reg << 1) | NW'(div_ge);
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                row_next   = 3'($countones(row_hits));
                col_next   = 3'($countones(col_hits));
                ci_ok_next = q_reg < n;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    in_image_next  = inside_reg;
                    if (!inside_reg)
                    begin
                        level_next = '0;
                        alpha_next = '0;
                    end
                    else if (ink)
                    begin
                        level_next = tog_pkg::INK_LEVEL;
                        alpha_next = tog_pkg::INK_ALPHA;
                    end
                    else
                    begin
                        level_next = '0;
                        alpha_next = tog_pkg::BOX_ALPHA;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            scale_reg       <= tog_pkg::SCALE_W'(1);
            text_length_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    tog_pkg::CFG_SCALE:       scale_reg <= cfg_data[tog_pkg::SCALE_W-1:0];
                    tog_pkg::CFG_TEXT_LENGTH: text_length_reg <= cfg_data;
                    default:                  scale_reg <= scale_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        roff_reg     <= roff_next;
        inside_reg   <= inside_next;
        area_reg     <= area_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        ci_ok_reg    <= ci_ok_next;
        level_reg    <= level_next;
        alpha_reg    <= alpha_next;
        in_image_reg <= in_image_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.red      = level_reg;
    assign result.green    = level_reg;
    assign result.blue     = level_reg;
    assign result.alpha    = alpha_reg;
    assign result.in_image = in_image_reg;

    a_query_holds_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == tog_pkg::FUNC_QUERY) |=> !item.ready)
        else $error("item channel ready right after a query transaction");

    a_write_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == tog_pkg::FUNC_WRITE && !result.valid) |=> !result.valid)
        else $error("write transaction produced a result");

    a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (result.valid && item.ready))
        else $error("finished query did not reach the output register");

    a_outside_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.in_image) |-> (result.alpha == '0 && result.red == '0))
        else $error("pixel outside the image carries color");

endmodule
